### design/infix_to_postfix_converter_unit_macros.svh
// Assertion macros for the infix-to-postfix converter.
// Used by infix_to_postfix_converter_unit.sv; expects clk and rst_n in scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("converter check failed");

// Next-cycle implication, checked out of reset.
`define IPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("converter check failed");

`endif

### design/ipc_pkg.sv
// Shared types, constants and character classifiers for the converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ipc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_expr;
  } ipc_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       run_last;
    logic       expr_done;
    logic       overflow_seen;
  } ipc_out_t;

  // Per-cycle move of the stack chain: push shifts down, pop shifts up.
  typedef struct packed {
    logic push;
    logic pop;
  } ipc_shift_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9);
  endfunction

  function automatic logic is_opener(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACE) || (c == CH_LBRACK);
  endfunction

  function automatic logic is_closer(input logic [7:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACE) || (c == CH_RBRACK);
  endfunction

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_PLUS, CH_MINUS: p = 2'd1;
      CH_STAR, CH_SLASH: p = 2'd2;
      CH_CARET:          p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  // True when stack entry t leaves the stack ahead of incoming operator c.
  function automatic logic pops_before(input logic [7:0] c, input logic [7:0] t);
    logic r;
    if (c == CH_CARET) begin
      r = prec_of(t) > prec_of(c);
    end else begin
      r = prec_of(t) >= prec_of(c);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/ipc_stack_cell.sv
// One stack cell: holds one entry, takes from its upper or lower neighbor.
// Depends on ipc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipc_stack_cell (
  input  wire logic               clk,
  input  ipc_pkg::ipc_shift_t     shift,
  input  wire logic [7:0]         from_above,
  input  wire logic [7:0]         from_below,
  output logic [7:0]              entry
);
  import ipc_pkg::*;

  logic [7:0] entry_r;

  // Payload only: no reset, occupancy lives in the count.
  always_ff @(posedge clk) begin
    if (shift.push) begin
      entry_r <= from_above;
    end else if (shift.pop) begin
      entry_r <= from_below;
    end
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

### design/ipc_op_stack.sv
// Operator stack as a chain of STACK_DEPTH cells; cell 0 is the top.
// Depends on ipc_pkg and ipc_stack_cell.
`timescale 1ns / 1ps
`default_nettype none

module ipc_op_stack (
  input  wire logic           clk,
  input  ipc_pkg::ipc_shift_t shift,
  input  wire logic [7:0]     push_data,
  output logic [7:0]          top_entry,
  output logic [7:0]          second_entry
);
  import ipc_pkg::*;

  logic [7:0] ent [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] above;
    logic [7:0] below;
    if (i == 0) begin : g_top
      assign above = push_data;
    end else begin : g_mid
      assign above = ent[i-1];
    end
    // Bottom cell holds its value on pop; anything below the count is don't-care.
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = ent[i];
    end else begin : g_inner
      assign below = ent[i+1];
    end
    ipc_stack_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_above (above),
      .from_below (below),
      .entry      (ent[i])
    );
  end

  assign top_entry    = ent[0];
  assign second_entry = ent[1];

endmodule

`default_nettype wire

### design/infix_to_postfix_converter_unit.sv
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on ipc_pkg, ipc_op_stack and infix_to_postfix_converter_unit_macros.svh.
// Usage:
//   in_*  : one expression character per beat (char_in, end_of_expr).
//   out_* : one postfix character per beat, plus run_last, expr_done and the
//           sticky overflow flag; a bare terminator (char_valid 0) ends each
//           expression.
// Timing:
//   An item is taken in ST_IDLE and worked in ST_PROC in the next cycle; a push
//   finishes there, and a letter or digit finishes there once the output
//   register can take it. An operator or closer pops stack entries one at a
//   time, as the cell chain shifts by one entry per cycle and one result
//   leaves per cycle while out_ready allows. An item marked last then drains
//   the remaining entries in ST_FLUSH, sees the stack empty and sends the
//   terminator in ST_TERM. Results show on out_valid from the output register.
// Reset:
//   rst_n low empties the stack, clears the overflow flag and the output
//   valid. Stack cells need no clearing: only counted entries are read.
// Backpressure:
//   Results sit in an output register; while it is full and out_ready is low,
//   steps that emit hold, and no new item is taken until the work is done.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  ipc_pkg::ipc_in_t   in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ipc_pkg::ipc_out_t  out_data
);
  import ipc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROC  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_TERM  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       cur_char_r;
  logic             cur_last_r;
  logic             out_valid_r;
  ipc_out_t         out_data_r;

  ipc_shift_t       shift;
  logic [7:0]       top_e;
  logic [7:0]       sec_e;
  logic             emit;
  ipc_out_t         emit_data;
  logic             load_ok;
  logic             has1;
  logic             has2;
  logic             full;
  logic [1:0]       done_state;

  ipc_op_stack u_stack (
    .clk          (clk),
    .shift        (shift),
    .push_data    (cur_char_r),
    .top_entry    (top_e),
    .second_entry (sec_e)
  );

  assign load_ok    = !out_valid_r || out_ready;
  assign has1       = count_r != '0;
  assign has2       = count_r > CNT_W'(1);
  assign full       = count_r == CNT_W'(STACK_DEPTH);
  assign done_state = cur_last_r ? ST_FLUSH : ST_IDLE;
  assign in_ready   = state_r == ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    shift     = '0;
    emit      = 1'b0;
    emit_data = '{char_out: top_e, char_valid: 1'b1, run_last: 1'b0,
                  expr_done: 1'b0, overflow_seen: ovf_r};
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PROC;
        end
      end
      ST_PROC: begin
        if (is_alnum(cur_char_r)) begin
          // Pass through straight to the output.
          if (load_ok) begin
            emit               = 1'b1;
            emit_data.char_out = cur_char_r;
            emit_data.run_last = !cur_last_r;
            state_nxt          = done_state;
          end
        end else if (is_opener(cur_char_r)) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            shift.push = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
          end
          state_nxt = done_state;
        end else if (is_closer(cur_char_r)) begin
          if (has1 && !is_opener(top_e)) begin
            // Pop one operator; look one cell down to flag the final result.
            if (load_ok) begin
              emit               = 1'b1;
              emit_data.run_last = !cur_last_r && !(has2 && !is_opener(sec_e));
              shift.pop          = 1'b1;
              count_nxt          = count_r - CNT_W'(1);
            end
          end else begin
            // Drop the opening bracket, if any, without checking the pair.
            if (has1) begin
              shift.pop = 1'b1;
              count_nxt = count_r - CNT_W'(1);
            end
            state_nxt = done_state;
          end
        end else begin
          if (has1 && pops_before(cur_char_r, top_e)) begin
            if (load_ok) begin
              emit               = 1'b1;
              emit_data.run_last = !cur_last_r &&
                                   !(has2 && pops_before(cur_char_r, sec_e));
              shift.pop          = 1'b1;
              count_nxt          = count_r - CNT_W'(1);
            end
          end else begin
            if (full) begin
              ovf_nxt = 1'b1;
            end else begin
              shift.push = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
            end
            state_nxt = done_state;
          end
        end
      end
      ST_FLUSH: begin
        // Drain everything, brackets included; the terminator closes the run.
        if (has1) begin
          if (load_ok) begin
            emit      = 1'b1;
            shift.pop = 1'b1;
            count_nxt = count_r - CNT_W'(1);
          end
        end else begin
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        if (load_ok) begin
          emit                 = 1'b1;
          emit_data.char_out   = '0;
          emit_data.char_valid = 1'b0;
          emit_data.run_last   = 1'b1;
          emit_data.expr_done  = 1'b1;
          ovf_nxt              = 1'b0;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture the item on accept, the result on emit.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_char_r <= in_data.char_in;
      cur_last_r <= in_data.end_of_expr;
    end
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "infix_to_postfix_converter_unit_macros.svh"

  `IPC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(STACK_DEPTH))
  `IPC_ASSERT_NEXT(a_accept_to_proc, in_valid && in_ready, state_r == ST_PROC)
  `IPC_ASSERT_NEXT(a_term_clears_ovf, emit && state_r == ST_TERM, !ovf_r && count_r == '0)
  `IPC_ASSERT_NOW(a_done_is_term, out_valid_r && out_data_r.expr_done, out_data_r.run_last && !out_data_r.char_valid)

endmodule

`default_nettype wire
